### src/exs_pkg.sv
// shared types for the exchange sorter
package exs_pkg;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the broadcast value into the sorted chain
    logic shift;   // move every cell one step toward the head
  } exs_ctrl_t;

  // sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } exs_state_t;

endpackage

### src/exs_if.sv
// stream interfaces for list input and sorted output
interface exs_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface exs_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sorted_value;
  logic                         is_final;
  logic                         overflowed;

  modport source (output valid, output sorted_value, output is_final, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_value, input is_final, input overflowed,
                  output ready);
endinterface

### src/exs_cell.sv
// one compare cell of the insertion chain
module exs_cell
  import exs_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  exs_ctrl_t                    ctrl,
  input  logic signed [DATA_WIDTH-1:0] new_value,
  input  logic signed [DATA_WIDTH-1:0] left_data,
  input  logic                         left_valid,
  input  logic                         left_gt,
  input  logic signed [DATA_WIDTH-1:0] right_data,
  input  logic                         right_valid,
  output logic signed [DATA_WIDTH-1:0] data,
  output logic                         valid,
  output logic                         gt
);

  // empty cells behave as +infinity
  assign gt = !valid || (data > new_value);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= right_data;
    end else if (ctrl.insert && gt) begin
      data <= left_gt ? left_data : new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.insert && gt) begin
      valid <= left_gt ? left_valid : 1'b1;
    end
  end

endmodule

### src/exchange_sorter.sv
// exchange_sorter: insertion chain of compare cells, emits each list in ascending order
// loading takes one element per cycle with no stall; the list is emitted one value per
// cycle while results.ready is high, starting the cycle after the last element, n results
// for an n-element list with n <= MAX_LEN; while results drain no new element is accepted
// reset empties the chain and clears the overflow flag; cell data is not reset
module exchange_sorter
  import exs_pkg::*;
#(
  parameter int MAX_LEN    = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  exs_in_if.sink    items,
  exs_out_if.source results
);

  exs_state_t state;
  exs_state_t state_next;
  logic       overflow;
  exs_ctrl_t  ctrl;

  logic signed [DATA_WIDTH-1:0] cell_data  [MAX_LEN];
  logic                         cell_valid [MAX_LEN];
  logic                         cell_gt    [MAX_LEN];

  logic in_take;
  logic out_take;
  logic full;
  logic final_item;

  // the chain is full once its tail cell holds an element
  assign full       = cell_valid[MAX_LEN-1];
  assign final_item = !cell_valid[1];

  assign items.ready = (state == ST_LOAD);
  assign in_take     = items.valid && items.ready;

  // head cell feeds the output directly
  assign results.valid        = (state == ST_DRAIN) && cell_valid[0];
  assign results.sorted_value = cell_data[0];
  assign results.is_final     = final_item;
  assign results.overflowed   = overflow;
  assign out_take             = results.valid && results.ready;

  // an element arriving at a full chain is dropped
  assign ctrl.insert = in_take && !full;
  assign ctrl.shift  = out_take;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_take && items.is_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_take && final_item) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      overflow <= 1'b0;
    end else begin
      state <= state_next;
      if (out_take && final_item) begin
        overflow <= 1'b0;
      end else if (in_take && full) begin
        overflow <= 1'b1;
      end
    end
  end

  // row of cells: each sees its left neighbor for insertion shifts
  // and its right neighbor for draining toward the head
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] l_data;
    logic                         l_valid;
    logic                         l_gt;
    logic signed [DATA_WIDTH-1:0] r_data;
    logic                         r_valid;

    if (i == 0) begin : g_head
      assign l_data  = '0;
      assign l_valid = 1'b0;
      assign l_gt    = 1'b0;
    end else begin : g_body
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
    end

    if (i == MAX_LEN - 1) begin : g_tail
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    exs_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_value  (items.value),
      .left_data  (l_data),
      .left_valid (l_valid),
      .left_gt    (l_gt),
      .right_data (r_data),
      .right_valid(r_valid),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i])
    );
  end

endmodule
